### design/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types, field widths and codes of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    // transaction field widths
    localparam int TYPE_W      = 2;
    localparam int RSIZE_W     = 17;
    localparam int COUNT_W     = 16;
    localparam int OFFS_W      = 16;
    localparam int STATUS_W    = 2;
    localparam int COPY_W      = 17;
    localparam int TOTAL_W     = RSIZE_W + COUNT_W;

    // header store has one entry per 8-byte grain
    localparam int GRAIN_SH    = 3;

    typedef logic [TYPE_W-1:0]   t_req_type;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_req_type REQ_ALLOC   = 2'd0;
    localparam t_req_type REQ_RELEASE = 2'd1;
    localparam t_req_type REQ_RESIZE  = 2'd2;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_NULL = 2'd1;
    localparam t_status ST_OOM  = 2'd2;

    // datapath commands
    typedef logic [4:0] t_op;
    localparam t_op OP_NONE       = 5'd0;
    localparam t_op OP_LOAD       = 5'd1;
    localparam t_op OP_MUL        = 5'd2;
    localparam t_op OP_ALIGN      = 5'd3;
    localparam t_op OP_WALK_INIT  = 5'd4;
    localparam t_op OP_RD_A       = 5'd5;
    localparam t_op OP_RD_N       = 5'd6;
    localparam t_op OP_LATCH      = 5'd7;
    localparam t_op OP_STEP       = 5'd8;
    localparam t_op OP_FIT_SPLIT  = 5'd9;
    localparam t_op OP_FIT_TAKE   = 5'd10;
    localparam t_op OP_APPEND     = 5'd11;
    localparam t_op OP_LOC_HIT    = 5'd12;
    localparam t_op OP_REL_MARK   = 5'd13;
    localparam t_op OP_KEEP       = 5'd14;
    localparam t_op OP_SHR_SPLIT  = 5'd15;
    localparam t_op OP_SHR_TAKE   = 5'd16;
    localparam t_op OP_RELOC_FREE = 5'd17;
    localparam t_op OP_MRG_GROW   = 5'd18;
    localparam t_op OP_OOM        = 5'd19;
    localparam t_op OP_OUT        = 5'd20;

    // datapath status toward the controller
    typedef struct packed {
        t_req_type kind;
        logic      present;
        logic      poff_small;
        logic      zero;
        logic      big;
        logic      at_top;
        logic      loc_hit;
        logic      loc_past;
        logic      fit;
        logic      split;
        logic      room;
        logic      blk_free;
        logic      shrink_ok;
        logic      shrink_split;
        logic      nxt_end;
        logic      cur_free;
        logic      out_busy;
    } t_stat;

endpackage

### design/ffha_if.sv
// ----------------------------------------------------------------------------
// ffha_req_if / ffha_rsp_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface ffha_req_if import ffha_pkg::*; ();
    logic                valid;
    logic                ready;
    t_req_type           req_type;
    logic [RSIZE_W-1:0]  request_size;
    logic [COUNT_W-1:0]  element_count;
    logic [OFFS_W-1:0]   payload_offset;
    logic                payload_present;

    modport source (output valid, req_type, request_size, element_count,
                    payload_offset, payload_present, input ready);
    modport sink   (input valid, req_type, request_size, element_count,
                    payload_offset, payload_present, output ready);
endinterface

interface ffha_rsp_if import ffha_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OFFS_W-1:0]  result_offset;
    t_status            status;
    logic [COPY_W-1:0]  copy_length;

    modport source (output valid, result_offset, status, copy_length, input ready);
    modport sink   (input valid, result_offset, status, copy_length, output ready);
endinterface

### design/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### design/ffha_dp.sv
// ----------------------------------------------------------------------------
// ffha_dp
// Allocator datapath: request registers, size arithmetic, header store,
// walk/merge cursors and the response register.
// ----------------------------------------------------------------------------
module ffha_dp import ffha_pkg::*; #(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 24,
    parameter int ALIGN_BYTES  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_op                i_op,
    output t_stat              o_stat,
    input  t_req_type          i_req_type,
    input  logic [RSIZE_W-1:0] i_request_size,
    input  logic [COUNT_W-1:0] i_element_count,
    input  logic [OFFS_W-1:0]  i_payload_offset,
    input  logic               i_payload_present,
    input  logic               i_rsp_ready,
    output logic               o_rsp_valid,
    output logic [OFFS_W-1:0]  o_result_offset,
    output t_status            o_status,
    output logic [COPY_W-1:0]  o_copy_length
);
    localparam int AW    = $clog2(HEAP_BYTES) + 1;   // holds any size or address
    localparam int XW    = AW + 1;                   // headroom for sums
    localparam int DEPTH = HEAP_BYTES / (2 ** GRAIN_SH);
    localparam int IW    = $clog2(DEPTH);
    localparam int HW    = AW + 1;                   // free mark + size

    localparam logic [XW-1:0] HDR      = XW'(HEADER_BYTES);
    localparam logic [XW-1:0] HDR_ALN  = XW'(HEADER_BYTES + ALIGN_BYTES);
    localparam logic [XW-1:0] ALN_M1   = XW'(ALIGN_BYTES - 1);
    localparam logic [XW-1:0] ALN_MASK = ~ALN_M1;
    localparam logic [XW-1:0] HEAP     = XW'(HEAP_BYTES);
    localparam logic [TOTAL_W-1:0] HEAP_T = TOTAL_W'(HEAP_BYTES);

    // request registers
    t_req_type           r_kind;
    logic [RSIZE_W-1:0]  r_rsize;
    logic [COUNT_W-1:0]  r_count;
    logic [OFFS_W-1:0]   r_poff;
    logic                r_present;
    logic [TOTAL_W-1:0]  r_total;
    logic [XW-1:0]       r_aligned;
    logic                r_big;

    // heap and cursors
    logic [XW-1:0]       r_top;
    logic [XW-1:0]       r_a;
    logic [XW-1:0]       r_s;
    logic                r_f;
    logic [XW-1:0]       r_blk;
    logic [XW-1:0]       r_bs;
    logic                r_bf;
    logic [XW-1:0]       r_m;
    logic [XW-1:0]       r_ms;

    // result under construction and response register
    logic [XW-1:0]       r_result;
    t_status             r_status;
    logic [XW-1:0]       r_copy;
    logic                r_ovalid;
    logic [OFFS_W-1:0]   r_oresult;
    t_status             r_ostatus;
    logic [COPY_W-1:0]   r_ocopy;

    // arithmetic shared by several commands
    logic [XW-1:0] w_round, w_ah, w_poff, w_rest_a, w_rest_b, w_rem_a, w_rem_b;
    logic [XW-1:0] w_nxt, w_grow, w_step, w_top_end;
    logic          w_big;

    assign w_poff    = XW'(r_poff);
    assign w_round   = (r_total[XW-1:0] + ALN_M1) & ALN_MASK;
    assign w_big     = (r_total > HEAP_T) || (w_round > HEAP);
    assign w_ah      = r_a + HDR;
    assign w_step    = w_ah + r_s;
    assign w_rest_a  = w_ah + r_aligned;
    assign w_rest_b  = r_blk + HDR + r_aligned;
    assign w_rem_a   = r_s - r_aligned - HDR;
    assign w_rem_b   = r_bs - r_aligned - HDR;
    assign w_nxt     = r_m + HDR + r_ms;
    assign w_grow    = r_ms + HDR + r_s;
    assign w_top_end = r_top + HDR + r_aligned;

    // header store access
    logic          w_we, w_re;
    logic [XW-1:0] w_waddr, w_raddr;
    logic          w_wfree;
    logic [XW-1:0] w_wsize;
    logic [HW-1:0] w_rdata;

    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_waddr = r_a;
        w_raddr = r_a;
        w_wfree = 1'b0;
        w_wsize = r_s;
        case (i_op)
            OP_RD_A: begin
                w_re = 1'b1;
            end
            OP_RD_N: begin
                w_re    = 1'b1;
                w_raddr = w_nxt;
            end
            OP_FIT_SPLIT: begin
                w_we    = 1'b1;
                w_waddr = w_rest_a;
                w_wfree = 1'b1;
                w_wsize = w_rem_a;
            end
            OP_FIT_TAKE: begin
                w_we = 1'b1;
            end
            OP_APPEND: begin
                w_we    = 1'b1;
                w_waddr = r_top;
                w_wsize = r_aligned;
            end
            OP_REL_MARK, OP_RELOC_FREE: begin
                w_we    = 1'b1;
                w_waddr = r_blk;
                w_wfree = 1'b1;
                w_wsize = r_bs;
            end
            OP_SHR_SPLIT: begin
                w_we    = 1'b1;
                w_waddr = w_rest_b;
                w_wfree = 1'b1;
                w_wsize = w_rem_b;
            end
            OP_SHR_TAKE: begin
                w_we    = 1'b1;
                w_waddr = r_blk;
                w_wsize = r_aligned;
            end
            OP_MRG_GROW: begin
                w_we    = 1'b1;
                w_waddr = r_m;
                w_wfree = 1'b1;
                w_wsize = w_grow;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    ffha_ram #(
        .WIDTH (HW),
        .DEPTH (DEPTH)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr[IW+GRAIN_SH-1:GRAIN_SH]),
        .i_wdata ({w_wfree, w_wsize[AW-1:0]}),
        .i_re    (w_re),
        .i_raddr (w_raddr[IW+GRAIN_SH-1:GRAIN_SH]),
        .o_rdata (w_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_op == OP_APPEND) begin
                r_top <= w_top_end;
            end
            if (i_op == OP_OUT) begin
                r_ovalid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_kind    <= i_req_type;
                r_rsize   <= i_request_size;
                r_count   <= i_element_count;
                r_poff    <= i_payload_offset;
                r_present <= i_payload_present;
                r_result  <= '0;
                r_status  <= ST_NULL;
                r_copy    <= '0;
            end
            OP_MUL: begin
                if (r_kind == REQ_ALLOC) begin
                    r_total <= TOTAL_W'(r_count) * TOTAL_W'(r_rsize);
                end else begin
                    r_total <= TOTAL_W'(r_rsize);
                end
            end
            OP_ALIGN: begin
                r_aligned <= w_round;
                r_big     <= w_big;
            end
            OP_WALK_INIT: begin
                r_a <= '0;
            end
            OP_LATCH: begin
                r_s <= XW'(w_rdata[AW-1:0]);
                r_f <= w_rdata[AW];
            end
            OP_STEP: begin
                r_a <= w_step;
            end
            OP_FIT_SPLIT: begin
                r_s <= r_aligned;
            end
            OP_FIT_TAKE: begin
                r_result <= w_ah;
                r_status <= ST_OK;
            end
            OP_APPEND: begin
                r_result <= r_top + HDR;
                r_status <= ST_OK;
            end
            OP_LOC_HIT: begin
                r_blk <= r_a;
                r_bs  <= r_s;
                r_bf  <= r_f;
            end
            OP_REL_MARK: begin
                r_m      <= r_blk;
                r_ms     <= r_bs;
                r_status <= ST_OK;
            end
            OP_KEEP, OP_SHR_TAKE: begin
                r_result <= w_poff;
                r_status <= ST_OK;
            end
            OP_SHR_SPLIT: begin
                r_m  <= w_rest_b;
                r_ms <= w_rem_b;
            end
            OP_RELOC_FREE: begin
                r_copy <= r_bs;
                r_m    <= r_blk;
                r_ms   <= r_bs;
            end
            OP_MRG_GROW: begin
                r_ms <= w_grow;
            end
            OP_OOM: begin
                r_status <= ST_OOM;
                r_result <= '0;
            end
            OP_OUT: begin
                r_oresult <= OFFS_W'(r_result);
                r_ostatus <= r_status;
                r_ocopy   <= COPY_W'(r_copy);
            end
            default: begin
                r_a <= r_a;
            end
        endcase
    end

    // status toward the controller
    always_comb begin
        o_stat.kind         = r_kind;
        o_stat.present      = r_present;
        o_stat.poff_small   = w_poff < HDR;
        o_stat.zero         = (r_total == '0);
        o_stat.big          = r_big;
        o_stat.at_top       = r_a >= r_top;
        o_stat.loc_hit      = w_ah == w_poff;
        o_stat.loc_past     = w_ah > w_poff;
        o_stat.fit          = r_f && (r_s >= r_aligned);
        o_stat.split        = r_s > (r_aligned + HDR);
        o_stat.room         = w_top_end <= HEAP;
        o_stat.blk_free     = r_bf;
        o_stat.shrink_ok    = !r_big && (r_bs >= r_aligned);
        o_stat.shrink_split = r_bs >= (r_aligned + HDR_ALN);
        o_stat.nxt_end      = w_nxt >= r_top;
        o_stat.cur_free     = r_f;
        o_stat.out_busy     = r_ovalid && !i_rsp_ready;
    end

    assign o_rsp_valid     = r_ovalid;
    assign o_result_offset = r_oresult;
    assign o_status        = r_ostatus;
    assign o_copy_length   = r_ocopy;

    // heap top stays inside the arena and on a grain boundary
    a_top_in_arena: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= HEAP) else $error("heap top beyond arena");
    a_top_grain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top[GRAIN_SH-1:0] == '0) else $error("heap top off grain");
    // a new response is never loaded over one still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_OUT) |-> !(r_ovalid && !i_rsp_ready))
        else $error("response overwritten");
    // append only happens when it fits
    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_APPEND) |=> (r_top <= HEAP))
        else $error("append overflowed arena");
endmodule

### design/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// Allocator sequencer: decodes a request and steps the datapath through
// the first-fit walk, locate walk, split, append and forward merge.
// ----------------------------------------------------------------------------
module ffha_ctrl import ffha_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    output logic  o_req_ready,
    input  t_stat i_stat,
    output t_op   o_op
);
    localparam logic [4:0] S_IDLE        = 5'd0;
    localparam logic [4:0] S_MUL         = 5'd1;
    localparam logic [4:0] S_ALIGN       = 5'd2;
    localparam logic [4:0] S_DISP        = 5'd3;
    localparam logic [4:0] S_FIT_CHK     = 5'd4;
    localparam logic [4:0] S_FIT_LAT     = 5'd5;
    localparam logic [4:0] S_FIT_EVAL    = 5'd6;
    localparam logic [4:0] S_FIT_SPLIT   = 5'd7;
    localparam logic [4:0] S_FIT_TAKE    = 5'd8;
    localparam logic [4:0] S_APPEND      = 5'd9;
    localparam logic [4:0] S_ALLOC_END   = 5'd10;
    localparam logic [4:0] S_OOM         = 5'd11;
    localparam logic [4:0] S_LOC_CHK     = 5'd12;
    localparam logic [4:0] S_LOC_LAT     = 5'd13;
    localparam logic [4:0] S_LOC_EVAL    = 5'd14;
    localparam logic [4:0] S_REL_MARK    = 5'd15;
    localparam logic [4:0] S_RES_DEC     = 5'd16;
    localparam logic [4:0] S_SHR_SPLIT   = 5'd17;
    localparam logic [4:0] S_SHR_TAKE    = 5'd18;
    localparam logic [4:0] S_RELOC_FREE  = 5'd19;
    localparam logic [4:0] S_MRG_CHK     = 5'd20;
    localparam logic [4:0] S_MRG_LAT     = 5'd21;
    localparam logic [4:0] S_MRG_EVAL    = 5'd22;
    localparam logic [4:0] S_DONE        = 5'd23;

    logic [4:0] r_state, n_state;
    logic       w_alloc_like;

    assign o_req_ready  = (r_state == S_IDLE);
    assign w_alloc_like = (i_stat.kind == REQ_ALLOC) ||
                          ((i_stat.kind == REQ_RESIZE) && !i_stat.present);

    // next state and datapath command
    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_op    = OP_LOAD;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_op    = OP_MUL;
                n_state = S_ALIGN;
            end
            S_ALIGN: begin
                o_op    = OP_ALIGN;
                n_state = S_DISP;
            end
            S_DISP: begin
                o_op = OP_WALK_INIT;
                if (w_alloc_like) begin
                    if (i_stat.zero)      n_state = S_DONE;
                    else if (i_stat.big)  n_state = S_OOM;
                    else                  n_state = S_FIT_CHK;
                end else if ((i_stat.kind == REQ_RELEASE) ||
                             (i_stat.kind == REQ_RESIZE)) begin
                    if (!i_stat.present || i_stat.poff_small) n_state = S_DONE;
                    else                                      n_state = S_LOC_CHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            // first-fit walk
            S_FIT_CHK: begin
                o_op    = OP_RD_A;
                n_state = i_stat.at_top ? S_APPEND : S_FIT_LAT;
            end
            S_FIT_LAT: begin
                o_op    = OP_LATCH;
                n_state = S_FIT_EVAL;
            end
            S_FIT_EVAL: begin
                if (i_stat.fit) begin
                    n_state = i_stat.split ? S_FIT_SPLIT : S_FIT_TAKE;
                end else begin
                    o_op    = OP_STEP;
                    n_state = S_FIT_CHK;
                end
            end
            S_FIT_SPLIT: begin
                o_op    = OP_FIT_SPLIT;
                n_state = S_FIT_TAKE;
            end
            S_FIT_TAKE: begin
                o_op    = OP_FIT_TAKE;
                n_state = S_ALLOC_END;
            end
            S_APPEND: begin
                if (i_stat.room) begin
                    o_op    = OP_APPEND;
                    n_state = S_ALLOC_END;
                end else begin
                    n_state = S_OOM;
                end
            end
            S_ALLOC_END: begin
                // a resize of a live block frees the old one after relocating
                if ((i_stat.kind == REQ_RESIZE) && i_stat.present) n_state = S_RELOC_FREE;
                else                                                n_state = S_DONE;
            end
            S_OOM: begin
                o_op    = OP_OOM;
                n_state = S_DONE;
            end
            // locate walk
            S_LOC_CHK: begin
                o_op = OP_RD_A;
                if (i_stat.at_top || (i_stat.loc_past && !i_stat.loc_hit)) n_state = S_DONE;
                else                                                       n_state = S_LOC_LAT;
            end
            S_LOC_LAT: begin
                o_op    = OP_LATCH;
                n_state = S_LOC_EVAL;
            end
            S_LOC_EVAL: begin
                if (i_stat.loc_hit) begin
                    o_op    = OP_LOC_HIT;
                    n_state = (i_stat.kind == REQ_RELEASE) ? S_REL_MARK : S_RES_DEC;
                end else begin
                    o_op    = OP_STEP;
                    n_state = S_LOC_CHK;
                end
            end
            S_REL_MARK: begin
                o_op    = OP_REL_MARK;
                n_state = S_MRG_CHK;
            end
            S_RES_DEC: begin
                if (i_stat.blk_free) begin
                    n_state = S_DONE;
                end else if (i_stat.shrink_ok) begin
                    if (i_stat.shrink_split) begin
                        n_state = S_SHR_SPLIT;
                    end else begin
                        o_op    = OP_KEEP;
                        n_state = S_DONE;
                    end
                end else begin
                    o_op    = OP_WALK_INIT;
                    n_state = i_stat.big ? S_OOM : S_FIT_CHK;
                end
            end
            S_SHR_SPLIT: begin
                o_op    = OP_SHR_SPLIT;
                n_state = S_SHR_TAKE;
            end
            S_SHR_TAKE: begin
                o_op    = OP_SHR_TAKE;
                n_state = S_MRG_CHK;
            end
            S_RELOC_FREE: begin
                o_op    = OP_RELOC_FREE;
                n_state = S_MRG_CHK;
            end
            // forward merge
            S_MRG_CHK: begin
                o_op    = OP_RD_N;
                n_state = i_stat.nxt_end ? S_DONE : S_MRG_LAT;
            end
            S_MRG_LAT: begin
                o_op    = OP_LATCH;
                n_state = S_MRG_EVAL;
            end
            S_MRG_EVAL: begin
                if (i_stat.cur_free) begin
                    o_op    = OP_MRG_GROW;
                    n_state = S_MRG_CHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_op    = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // a request is only taken in idle and always ends in a response load
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == OP_LOAD) |-> (r_state == S_IDLE)) else $error("load outside idle");
    a_load_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == OP_LOAD) |=> (r_state == S_MUL)) else $error("load not followed by mul");
    a_idle_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && ($past(r_state) != S_IDLE)) |->
        ($past(o_op) == OP_OUT)) else $error("idle reached without response");
endmodule

### design/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap manager with split, append at heap top and forward merge.
// ----------------------------------------------------------------------------
// One request is handled at a time. The header store is a RAM with one write
// and one registered read port, so every header visited takes a read, a latch
// and a decide step; a request passes through setup (load, multiply, align,
// dispatch), then one such read, latch and decide per block walked by the
// first-fit or locate search and per block absorbed by a forward merge, plus
// its header writes. The response sits in an output register, so the next
// request is taken as soon as the previous one has been loaded there. The
// header store needs no clear after reset: only headers below the heap top are
// ever used. ALIGN_BYTES must be a power of two; HEADER_BYTES a multiple of eight.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator import ffha_pkg::*; #(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 24,
    parameter int ALIGN_BYTES  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ffha_req_if.sink  i_req,
    ffha_rsp_if.source o_rsp
);
    t_op   w_op;
    t_stat w_stat;
    logic  w_ready;

    ffha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_ready),
        .i_stat      (w_stat),
        .o_op        (w_op)
    );

    ffha_dp #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (w_op),
        .o_stat            (w_stat),
        .i_req_type        (i_req.req_type),
        .i_request_size    (i_req.request_size),
        .i_element_count   (i_req.element_count),
        .i_payload_offset  (i_req.payload_offset),
        .i_payload_present (i_req.payload_present),
        .i_rsp_ready       (o_rsp.ready),
        .o_rsp_valid       (o_rsp.valid),
        .o_result_offset   (o_rsp.result_offset),
        .o_status          (o_rsp.status),
        .o_copy_length     (o_rsp.copy_length)
    );

    assign i_req.ready = w_ready;
endmodule

### test/ffha_checker.sv
// ----------------------------------------------------------------------------
// ffha_checker
// Watches the request and response channels of the heap allocator, keeps its
// own copy of the block headers and the heap top, predicts each response and
// compares it field by field with the one the block returns.
// ----------------------------------------------------------------------------
module ffha_checker import ffha_pkg::*; #(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 24,
    parameter int ALIGN_BYTES  = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ffha_req_if   i_req,
    ffha_rsp_if   i_rsp,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRAINS = HEAP_BYTES >> GRAIN_SH;

    typedef struct {
        logic [OFFS_W-1:0] offset;
        t_status           status;
        logic [COPY_W-1:0] copy;
    } t_grant;

    // shadow heap: payload size and free mark per grain, plus heap top
    int unsigned blk_len  [GRAINS];
    bit          blk_vac  [GRAINS];
    int unsigned heap_end;
    t_grant      grants_due[$];

    function automatic int unsigned len_at(int unsigned a);
        return (a >> GRAIN_SH) < GRAINS ? blk_len[a >> GRAIN_SH] : 0;
    endfunction

    function automatic bit vac_at(int unsigned a);
        return (a >> GRAIN_SH) < GRAINS ? blk_vac[a >> GRAIN_SH] : 1'b0;
    endfunction

    function automatic void put_hdr(int unsigned a, int unsigned len, bit vac);
        if ((a >> GRAIN_SH) < GRAINS) begin
            blk_len[a >> GRAIN_SH] = len & 32'h7FFF_FFFF;
            blk_vac[a >> GRAIN_SH] = vac;
        end
    endfunction

    // absorb every free block that directly follows
    function automatic void absorb_next(int unsigned a);
        int unsigned nxt;
        forever begin
            nxt = a + HEADER_BYTES + len_at(a);
            if (nxt >= heap_end || !vac_at(nxt)) return;
            put_hdr(a, len_at(a) + HEADER_BYTES + len_at(nxt), vac_at(a));
        end
    endfunction

    // find the header whose payload starts at poff
    function automatic bit find_blk(int unsigned poff, output int unsigned a);
        int unsigned w;
        w = 0;
        a = 0;
        if (poff < HEADER_BYTES) return 1'b0;
        while (w < heap_end) begin
            if (w + HEADER_BYTES == poff) begin
                a = w;
                return 1'b1;
            end
            if (w + HEADER_BYTES > poff) return 1'b0;
            w += HEADER_BYTES + len_at(w);
        end
        return 1'b0;
    endfunction

    function automatic longint unsigned round_up(longint unsigned n);
        return ((n + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    endfunction

    // first-fit grant with split, else append at the heap top
    function automatic t_status grant(longint unsigned total, output int unsigned poff);
        longint unsigned need;
        int unsigned     w, s;
        poff = 0;
        if (total == 0) return ST_NULL;
        need = round_up(total);
        if (need > HEAP_BYTES) return ST_OOM;
        w = 0;
        while (w < heap_end) begin
            s = len_at(w);
            if (vac_at(w) && s >= need) begin
                if (s > need + HEADER_BYTES) begin
                    put_hdr(w + HEADER_BYTES + int'(need), s - int'(need) - HEADER_BYTES, 1'b1);
                    s = int'(need);
                end
                put_hdr(w, s, 1'b0);
                poff = w + HEADER_BYTES;
                return ST_OK;
            end
            w += HEADER_BYTES + s;
        end
        if (longint'(heap_end) + HEADER_BYTES + need > HEAP_BYTES) return ST_OOM;
        put_hdr(heap_end, int'(need), 1'b0);
        poff = heap_end + HEADER_BYTES;
        heap_end += HEADER_BYTES + int'(need);
        return ST_OK;
    endfunction

    function automatic t_grant serve(t_req_type kind, longint unsigned rsize,
                                     longint unsigned cnt, int unsigned poff, bit present);
        t_grant          g;
        int unsigned     a, s, res, rest;
        longint unsigned need;
        g.status = ST_NULL;
        g.copy   = '0;
        res      = 0;
        case (kind)
            REQ_ALLOC: g.status = grant(cnt * rsize, res);
            REQ_RELEASE: begin
                if (present && find_blk(poff, a)) begin
                    put_hdr(a, len_at(a), 1'b1);
                    absorb_next(a);
                    g.status = ST_OK;
                end
            end
            REQ_RESIZE: begin
                if (!present) begin
                    g.status = grant(rsize, res);
                end else if (find_blk(poff, a) && !vac_at(a)) begin
                    need = round_up(rsize);
                    s    = len_at(a);
                    if (s >= need) begin
                        if (s >= need + HEADER_BYTES + ALIGN_BYTES) begin
                            rest = a + HEADER_BYTES + int'(need);
                            put_hdr(rest, s - int'(need) - HEADER_BYTES, 1'b1);
                            put_hdr(a, int'(need), 1'b0);
                            absorb_next(rest);
                        end
                        res      = poff;
                        g.status = ST_OK;
                    end else begin
                        g.status = grant(need, res);
                        if (g.status == ST_OK) begin
                            g.copy = COPY_W'(s);
                            put_hdr(a, s, 1'b1);
                            absorb_next(a);
                        end else begin
                            res = 0;
                        end
                    end
                end
            end
            default: ;  // unused request code: nothing done
        endcase
        g.offset = res[OFFS_W-1:0];
        return g;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    assign o_pending = grants_due.size();

    always @(posedge i_clk) begin
        t_grant g;
        if (!i_rst_n) begin
            foreach (blk_len[k]) begin
                blk_len[k] = 0;
                blk_vac[k] = 1'b0;
            end
            heap_end     = 0;
            grants_due.delete();
            o_fail_count = 0;
        end else begin
            // predict each accepted request
            if (i_req.valid && i_req.ready)
                grants_due.push_back(serve(i_req.req_type, i_req.request_size,
                    i_req.element_count, i_req.payload_offset, i_req.payload_present));
            // compare each accepted response with the oldest prediction
            if (i_rsp.valid && i_rsp.ready) begin
                if (grants_due.size() == 0) begin
                    $display("%0t response with no request outstanding", $realtime);
                    o_fail_count++;
                end else begin
                    g = grants_due.pop_front();
                    if (i_rsp.status !== g.status)
                        report("status", i_rsp.status, g.status);
                    if (i_rsp.result_offset !== g.offset)
                        report("result_offset", i_rsp.result_offset, g.offset);
                    if (i_rsp.copy_length !== g.copy)
                        report("copy_length", i_rsp.copy_length, g.copy);
                end
            end
        end
    end

endmodule

### test/first_fit_heap_allocator_tb.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Drives directed and random allocate, release, resize and unused-code
// transactions into the heap allocator under varying back-pressure; the checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_tb import ffha_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_RANDOM   = 400;
    localparam t_req_type REQ_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   tx_idle_pct;
    int   rx_idle_pct;
    logic [OFFS_W-1:0] live_ptrs[$];

    ffha_req_if req_if ();
    ffha_rsp_if rsp_if ();

    first_fit_heap_allocator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    ffha_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // response back-pressure
    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // remember granted payloads so releases and resizes hit real blocks
    always @(posedge i_clk) begin
        if (rsp_if.valid && rsp_if.ready && rsp_if.status == ST_OK
                && rsp_if.result_offset != 0)
            live_ptrs.push_back(rsp_if.result_offset);
    end

    task automatic send(t_req_type kind, logic [RSIZE_W-1:0] rsize,
                        logic [COUNT_W-1:0] cnt, logic [OFFS_W-1:0] poff, logic present);
        if ($urandom_range(99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_if.valid           <= 1'b1;
        req_if.req_type        <= kind;
        req_if.request_size    <= rsize;
        req_if.element_count   <= cnt;
        req_if.payload_offset  <= poff;
        req_if.payload_present <= present;
        // ready is stable by the falling edge; the transfer is the next rising one
        forever begin
            @(negedge i_clk);
            if (req_if.ready) break;
        end
        @(posedge i_clk);
    endtask

    function automatic logic [OFFS_W-1:0] pick_ptr(bit take);
        int k;
        logic [OFFS_W-1:0] p;
        if (live_ptrs.size() == 0) return OFFS_W'($urandom);
        k = $urandom_range(live_ptrs.size() - 1);
        p = live_ptrs[k];
        if (take) live_ptrs.delete(k);
        return p;
    endfunction

    function automatic logic [RSIZE_W-1:0] rand_size();
        int r;
        r = $urandom_range(99);
        if (r < 60) return RSIZE_W'($urandom_range(1, 256));
        if (r < 90) return RSIZE_W'($urandom_range(257, 2048));
        if (r < 97) return RSIZE_W'($urandom_range(2049, 20000));
        return RSIZE_W'($urandom);
    endfunction

    // stimulus
    initial begin
        int r;
        i_rst_n                = 1'b0;
        req_if.valid           = 1'b0;
        req_if.req_type        = REQ_ALLOC;
        req_if.request_size    = '0;
        req_if.element_count   = '0;
        req_if.payload_offset  = '0;
        req_if.payload_present = 1'b0;
        tx_idle_pct            = 30;
        rx_idle_pct            = 62;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero size, oversized, first blocks, null and unknown pointers
        send(REQ_ALLOC,   17'd0,      16'd1,      16'd0,      1'b0);
        send(REQ_ALLOC,   17'h10000,  16'd1,      16'd0,      1'b0);
        send(REQ_ALLOC,   17'd65535,  16'd1,      16'd0,      1'b0);
        send(REQ_ALLOC,   17'd1,      16'hFFFF,   16'd0,      1'b0);
        send(REQ_ALLOC,   17'h1FFFF,  16'hFFFF,   16'd0,      1'b0);
        send(REQ_ALLOC,   17'd1,      16'd1,      16'd0,      1'b0);  // payload 24
        send(REQ_ALLOC,   17'd100,    16'd1,      16'd0,      1'b0);  // payload 64
        send(REQ_ALLOC,   17'd50,     16'd4,      16'd0,      1'b0);  // payload 200
        send(REQ_ALLOC,   17'd0,      16'd0,      16'd0,      1'b1);
        send(REQ_RELEASE, 17'd0,      16'd0,      16'd24,     1'b0);
        send(REQ_RELEASE, 17'd0,      16'd0,      16'hFFFF,   1'b1);
        send(REQ_RELEASE, 17'd0,      16'd0,      16'd8,      1'b1);
        send(REQ_RELEASE, 17'd0,      16'd0,      16'd24,     1'b1);
        send(REQ_RELEASE, 17'd0,      16'd0,      16'd24,     1'b1);  // already free
        send(REQ_RESIZE,  17'd8,      16'd0,      16'd24,     1'b1);  // free block
        send(REQ_RESIZE,  17'd40,     16'd9,      16'd0,      1'b0);  // null: allocate
        send(REQ_RESIZE,  17'd0,      16'd0,      16'd0,      1'b0);  // null, zero size
        send(REQ_RESIZE,  17'd16,     16'd0,      16'd200,    1'b1);  // shrink, split
        send(REQ_RESIZE,  17'd500,    16'd0,      16'd64,     1'b1);  // relocate
        send(REQ_RESIZE,  17'h10000,  16'd0,      16'd200,    1'b1);  // relocate fails
        send(REQ_RESIZE,  17'd10,     16'd0,      16'h5555,   1'b1);  // unknown
        send(REQ_UNUSED,  17'h1FFFF,  16'hFFFF,   16'hFFFF,   1'b1);
        send(REQ_UNUSED,  17'd0,      16'd0,      16'h0000,   1'b0);

        // random mix; idling pattern changes by thirds
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                tx_idle_pct = 62;
                rx_idle_pct = 30;
            end else if (n == 2 * N_RANDOM / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            r = $urandom_range(99);
            if (r < 42)
                send(REQ_ALLOC, rand_size(),
                     ($urandom_range(9) == 0) ? COUNT_W'($urandom_range(0, 40)) : 16'd1,
                     OFFS_W'($urandom), 1'($urandom));
            else if (r < 47)
                send(REQ_ALLOC, RSIZE_W'($urandom), COUNT_W'($urandom),
                     OFFS_W'($urandom), 1'($urandom));
            else if (r < 72)
                send(REQ_RELEASE, RSIZE_W'($urandom), COUNT_W'($urandom),
                     pick_ptr(1'b1), 1'b1);
            else if (r < 77)
                send(REQ_RELEASE, RSIZE_W'($urandom), COUNT_W'($urandom),
                     OFFS_W'($urandom), 1'($urandom));
            else if (r < 93)
                send(REQ_RESIZE, rand_size(), COUNT_W'($urandom), pick_ptr(1'b0), 1'b1);
            else if (r < 97)
                send(REQ_RESIZE, rand_size(), COUNT_W'($urandom),
                     OFFS_W'($urandom), 1'($urandom));
            else
                send(REQ_UNUSED, RSIZE_W'($urandom), COUNT_W'($urandom),
                     OFFS_W'($urandom), 1'($urandom));
        end
        req_if.valid <= 1'b0;

        // drain once the last transaction is counted, then let the block settle
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS first_fit_heap_allocator");
        else
            $display("FAIL first_fit_heap_allocator");
        $finish;
    end

    // watchdog
    initial begin
        #200ms;
        $display("FAIL first_fit_heap_allocator");
        $finish;
    end

endmodule
